// ===== rtl/core/mfre_pkg.sv =====
// Package for the monochrome frame store raster engine.
// Holds opcode, fill mode and sequencer state types plus size constants.
// No dependencies.
`default_nettype none
package mfre_pkg;
   localparam int FRAME_BYTES_DEFAULT     = 65536;
   localparam int MAX_LINE_PIXELS_DEFAULT = 1024;
   localparam logic [10:0] LINE_PIXELS_RESET = 11'd640;
   localparam logic [10:0] LINE_COUNT_RESET  = 11'd384;

   typedef enum logic [2:0] {
      OP_FILL   = 3'd0,
      OP_INVERT = 3'd1,
      OP_FLIPV  = 3'd2,
      OP_MIRROR = 3'd3,
      OP_READ   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      FILL_WHITE = 2'd0,
      FILL_BLACK = 2'd1,
      FILL_XOR   = 2'd2,
      FILL_GRAY  = 2'd3
   } fill_mode_type;

   localparam logic CSR_LINE_PIXELS = 1'b0;
   localparam logic CSR_LINE_COUNT  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_WAIT,
      ST_WR_A,
      ST_WR_B,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7-i] = v[i];
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mfre_store.sv =====
// Frame store: one synchronous memory, one read and one write port.
// Read data is registered: it appears in the cycle after the address. Uses mfre_pkg.
`default_nettype none
module mfre_store #(
   parameter int AddrBits = 16
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AddrBits-1:0] wr_addr,
   input  wire logic [7:0]          wr_data,
   input  wire logic [AddrBits-1:0] rd_addr,
   output logic      [7:0]          rd_data
);
   import mfre_pkg::*;
   logic [7:0] mem [2**AddrBits];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/mono_framebuffer_raster_engine_core.sv =====
// Top level of the monochrome raster engine: command sequencer around mfre_store.
// Depends on mfre_pkg and mfre_store.
//
// Channel | Ports                                         | Handshake
// req     | req_opcode .. req_byte_address                | start high, busy low
// rsp     | rsp_read_data, rsp_status                     | done strobe, one cycle
// csr     | csr_index, csr_data                           | csr_valid and csr_ready
//
// After reset a clearing pass zeroes store bytes 0 to FRAME_BYTES-1, busy high.
// Fill and invert use RD_A, WR_A per byte; fill walks the clipped rectangle rows.
// Flip and mirror swap pairs in RD_A, RD_B, WAIT, WR_B, WR_A; mirror middle: RD_A, WR_A.
// Each command ends in ST_DONE, the done strobe; a valid read passes ST_READ_WAIT first.
// The single store port pair sets the pace. The receiver cannot stall.
`default_nettype none
module mono_framebuffer_raster_engine_core #(
   parameter int FRAME_BYTES     = mfre_pkg::FRAME_BYTES_DEFAULT,
   parameter int MAX_LINE_PIXELS = mfre_pkg::MAX_LINE_PIXELS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic signed [10:0] req_rect_left,
   input  wire logic signed [10:0] req_rect_top,
   input  wire logic [10:0] req_rect_width,
   input  wire logic [10:0] req_rect_height,
   input  wire logic [1:0]  req_fill_mode,
   input  wire logic [15:0] req_byte_address,
   output logic             done,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_data
);
   import mfre_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int TW = AW + 2;

   // Registers.
   state_type state_ff, state_in;
   logic [10:0] lpix_ff, lcnt_ff;
   logic [2:0]  op_ff, op_in;
   logic [1:0]  mode_ff, mode_in;
   logic [AW:0] clr_ff, clr_in;
   logic [11:0] y_ff, y_in, yend_ff, yend_in;
   logic [11:0] x_ff, x_in, xs_ff, xs_in, xend_ff, xend_in;
   logic [11:0] px0_ff, px0_in, px1_ff, px1_in;
   logic [TW-1:0] base_ff, base_in, addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic [TW-1:0] bbase_ff, bbase_in;
   logic [7:0]  da_ff, da_in, rdata_ff, rdata_in;
   logic        stat_ff, stat_in;

   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]  wr_data, rd_data;

   mfre_store #(.AddrBits(AW)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Frame geometry.
   logic [7:0]  row_bytes;
   logic [18:0] total;
   logic        bad_frame;
   assign row_bytes = lpix_ff[10:3];
   assign total     = 19'(row_bytes) * 19'(lcnt_ff);
   assign bad_frame = (32'(lpix_ff) > 32'(MAX_LINE_PIXELS)) || (32'(total) > 32'(FRAME_BYTES));

   // Clipped rectangle bounds computed from the request.
   logic signed [12:0] l_s, t_s, r_s, b_s;
   logic [11:0] fw;
   assign fw  = {1'b0, row_bytes, 3'b000};
   assign l_s = 13'(req_rect_left);
   assign t_s = 13'(req_rect_top);
   assign r_s = l_s + signed'({2'b00, req_rect_width});
   assign b_s = t_s + signed'({2'b00, req_rect_height});

   // Pixel mask and modified byte for fill.
   logic [7:0] fmask, fgray, fbyte, rev_b;
   logic [11:0] bx;
   assign bx = {x_ff[8:0], 3'b000};
   always_comb begin
      fmask = '0;
      fgray = '0;
      for (int k = 0; k < 8; k++) begin
         if ((bx + 12'(k)) >= px0_ff && (bx + 12'(k)) < px1_ff) fmask[7-k] = 1'b1;
         fgray[7-k] = bx[0] ^ k[0] ^ y_ff[0];
      end
      case (fill_mode_type'(mode_ff))
         FILL_WHITE: fbyte = rd_data & ~fmask;
         FILL_BLACK: fbyte = rd_data | fmask;
         FILL_XOR:   fbyte = rd_data ^ fmask;
         default:    fbyte = (rd_data & ~fmask) | (fgray & fmask);
      endcase
   end
   assign rev_b = bit_reverse8(rd_data);

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;

   // Next state and store access.
   always_comb begin
      state_in = state_ff; op_in = op_ff; mode_in = mode_ff; clr_in = clr_ff;
      y_in = y_ff; yend_in = yend_ff; x_in = x_ff; xs_in = xs_ff; xend_in = xend_ff;
      px0_in = px0_ff; px1_in = px1_ff; base_in = base_ff; bbase_in = bbase_ff;
      addr_a_in = addr_a_ff; addr_b_in = addr_b_ff; da_in = da_ff;
      rdata_in = rdata_ff; stat_in = stat_ff;
      wr_en = 1'b0; wr_addr = addr_a_ff[AW-1:0]; wr_data = '0;
      rd_addr = addr_a_ff[AW-1:0];
      done = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff[AW-1:0]; wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(FRAME_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            // The read byte is fetched in the accepting cycle itself.
            rd_addr = AW'(req_byte_address);
            if (start) begin
               op_in = req_opcode; mode_in = req_fill_mode;
               rdata_in = '0; stat_in = 1'b0;
               y_in = '0; x_in = '0; xs_in = '0; base_in = '0;
               xend_in = 12'(row_bytes); yend_in = 12'(lcnt_ff);
               bbase_in = TW'(total) - TW'(row_bytes);
               state_in = ST_DONE;
               if (bad_frame || req_opcode > OP_READ) begin
                  stat_in = 1'b1;
               end else begin
                  case (opcode_type'(req_opcode))
                     OP_FILL: begin
                        px0_in = (l_s < 0) ? 12'd0 : 12'(l_s);
                        px1_in = (r_s > signed'({1'b0, fw})) ? fw
                               : (r_s < 0 ? 12'd0 : 12'(r_s));
                        y_in    = (t_s < 0) ? 12'd0 : 12'(t_s);
                        yend_in = (b_s > signed'({2'b00, lcnt_ff})) ? 12'(lcnt_ff)
                                : (b_s < 0 ? 12'd0 : 12'(b_s));
                        xs_in   = 12'(px0_in[11:3]);
                        xend_in = 12'((px1_in + 12'd7) >> 3);
                        x_in    = xs_in;
                        base_in = TW'(y_in) * TW'(row_bytes);
                        if (px0_in < px1_in && y_in < yend_in) state_in = ST_RD_A;
                     end
                     OP_INVERT: if (total != 0 && row_bytes != 0) state_in = ST_RD_A;
                     OP_FLIPV: begin
                        yend_in = 12'(lcnt_ff >> 1);
                        if (yend_in != 0 && row_bytes != 0) state_in = ST_RD_A;
                     end
                     OP_MIRROR: if (total != 0) state_in = ST_RD_A;
                     default: begin
                        if (19'(req_byte_address) < total
                            && 32'(req_byte_address) < 32'(FRAME_BYTES)) begin
                           addr_a_in = TW'(req_byte_address);
                           state_in = ST_READ_WAIT;
                        end else stat_in = 1'b1;
                     end
                  endcase
                  addr_a_in = (opcode_type'(req_opcode) == OP_READ) ? TW'(req_byte_address)
                            : base_in + TW'(x_in);
               end
            end
         end
         ST_READ_WAIT: begin
            state_in = ST_DONE;
         end
         ST_RD_A: begin
            // Present address A; for swaps also compute B.
            rd_addr = addr_a_ff[AW-1:0];
            if (op_ff == OP_FLIPV)
               addr_b_in = bbase_ff + TW'(x_ff);
            else
               addr_b_in = base_ff + TW'(row_bytes) - 1'b1 - TW'(x_ff);
            if ((op_ff == OP_FLIPV) || (op_ff == OP_MIRROR && addr_b_in != addr_a_ff))
               state_in = ST_RD_B;
            else state_in = ST_WR_A;
         end
         ST_RD_B: begin
            rd_addr = addr_b_ff[AW-1:0];
            da_in = rd_data;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            // B data arrives now; write it to A, keep A for B.
            wr_en = 1'b1; wr_addr = addr_a_ff[AW-1:0];
            wr_data = (op_ff == OP_MIRROR) ? rev_b : rd_data;
            state_in = ST_WR_B;
         end
         ST_WR_B: begin
            wr_en = 1'b1; wr_addr = addr_b_ff[AW-1:0];
            wr_data = (op_ff == OP_MIRROR) ? bit_reverse8(da_ff) : da_ff;
            state_in = ST_WR_A;
         end
         ST_WR_A: begin
            // Single-byte write for fill, invert and mirror middle byte.
            if (op_ff == OP_FILL || op_ff == OP_INVERT || op_ff == OP_MIRROR) begin
               if (!(op_ff == OP_MIRROR && addr_b_ff != addr_a_ff)) begin
                  wr_en = 1'b1;
                  wr_data = (op_ff == OP_FILL) ? fbyte
                          : (op_ff == OP_INVERT) ? ~rd_data : rev_b;
               end
            end
            // Advance.
            state_in = ST_RD_A;
            case (opcode_type'(op_ff))
               OP_INVERT: begin
                  // The byte address itself counts through the whole frame.
                  addr_a_in = addr_a_ff + 1'b1;
                  if (addr_a_in >= TW'(total)) state_in = ST_DONE;
               end
               OP_MIRROR: begin
                  x_in = x_ff + 1'b1;
                  if (x_in >= 12'((row_bytes + 8'd1) >> 1)) begin
                     x_in = '0; y_in = y_ff + 1'b1;
                     base_in = base_ff + TW'(row_bytes);
                     if (y_in >= 12'(lcnt_ff)) state_in = ST_DONE;
                  end
                  addr_a_in = base_in + TW'(x_in);
               end
               OP_FLIPV: begin
                  x_in = x_ff + 1'b1;
                  if (x_in >= 12'(row_bytes)) begin
                     x_in = '0; y_in = y_ff + 1'b1;
                     base_in = base_ff + TW'(row_bytes);
                     bbase_in = bbase_ff - TW'(row_bytes);
                     if (y_in >= yend_ff) state_in = ST_DONE;
                  end
                  addr_a_in = base_in + TW'(x_in);
               end
               default: begin
                  x_in = x_ff + 1'b1;
                  if (x_in >= xend_ff) begin
                     x_in = xs_ff; y_in = y_ff + 1'b1;
                     base_in = base_ff + TW'(row_bytes);
                     if (y_in >= yend_ff) state_in = ST_DONE;
                  end
                  addr_a_in = base_in + TW'(x_in);
               end
            endcase
         end
         ST_DONE: begin
            done = 1'b1;
            if (op_ff == OP_READ && !stat_ff && !bad_frame) rdata_in = rdata_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // Capture read byte in ST_READ_WAIT, the cycle after its address.
      if (state_ff == ST_READ_WAIT) rdata_in = rd_data;
   end

   assign rsp_read_data = rdata_ff;
   assign rsp_status    = stat_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         lpix_ff  <= LINE_PIXELS_RESET;
         lcnt_ff  <= LINE_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LINE_PIXELS) lpix_ff <= csr_data;
            else lcnt_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in; mode_ff <= mode_in; y_ff <= y_in; yend_ff <= yend_in;
      x_ff <= x_in; xs_ff <= xs_in; xend_ff <= xend_in; px0_ff <= px0_in;
      px1_ff <= px1_in; base_ff <= base_in; bbase_ff <= bbase_in;
      addr_a_ff <= addr_a_in; addr_b_ff <= addr_b_in; da_ff <= da_in;
      rdata_ff <= rdata_in; stat_ff <= stat_in;
   end

   // Checks.
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done strobe lasted more than one cycle");
   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted command did not start");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en) else $error("store written while idle");
endmodule
`default_nettype wire
